>>> sv/rwv_pkg.sv
// ----------------------------------------------------------------------------
// Rolling window volatility package
// Constants, register codes and reset values shared by the volatility block.
// ----------------------------------------------------------------------------
package rwv_pkg;

  localparam int FRAC_BITS  = 20;
  localparam int OUT_W      = 32;
  localparam int SCALE_W    = 32;
  localparam int WLEN_W     = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 4'd0,
    REG_ANNUAL_SCALE  = 4'd1
  } cfg_reg_t;

  localparam logic [WLEN_W-1:0]  WLEN_RESET  = 7'd21;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd16645628;

endpackage

>>> sv/rwv_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the window update from the arithmetic.
// ----------------------------------------------------------------------------
module rwv_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/rwv_front.sv
// ----------------------------------------------------------------------------
// Window front end
// Accepts returns, keeps the sample ring and the running sum and sum of
// squares, and issues one job per sample once the window is full.
// ----------------------------------------------------------------------------
module rwv_front #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                in_sample,
  input  logic                                         in_start,
  input  logic [rwv_pkg::WLEN_W-1:0]                   window_length,
  input  logic                                         hist_clear,
  output logic                                         job_valid,
  input  logic                                         job_ready,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0] job_sum,
  output logic [2*SAMPLE_BITS-2+$clog2(MAX_WINDOW):0]  job_sq,
  output logic [$clog2(MAX_WINDOW+1)-1:0]              job_w
);

  import rwv_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int W_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + PTR_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + PTR_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_READ = 4'b0010,
    F_UPD  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t                   state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [2*SAMPLE_BITS-1:0]  x_sq_r, x_sq_nxt;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic [PTR_W-1:0]          wp_r, wp_nxt;
  logic [W_W-1:0]            fill_r, fill_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SQ_W-1:0]           sq_r, sq_nxt;

  logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

  logic [31:0]               wl_ext;
  logic [W_W-1:0]            w_eff;
  logic [PTR_W:0]            idx_sum;
  logic [PTR_W-1:0]          rd_idx;
  logic                      has_old;
  logic [2*SAMPLE_BITS-1:0]  old_sq;
  logic signed [SUM_W-1:0]   old_ext;
  logic [SQ_W-1:0]           old_sq_ext;
  logic                      mem_we;

  assign wl_ext = 32'(window_length);

  always_comb begin
    if (wl_ext < 32'd2) begin
      w_eff = W_W'(2);
    end else if (wl_ext > 32'(MAX_WINDOW)) begin
      w_eff = W_W'(MAX_WINDOW);
    end else begin
      w_eff = W_W'(wl_ext);
    end
  end

  assign idx_sum = {1'b0, wp_r} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(w_eff);
  assign rd_idx  = (idx_sum >= (PTR_W+1)'(MAX_WINDOW)) ?
                   PTR_W'(idx_sum - (PTR_W+1)'(MAX_WINDOW)) : idx_sum[PTR_W-1:0];

  assign has_old    = (fill_r >= w_eff);
  assign old_sq     = old_r * old_r;
  assign old_ext    = has_old ? SUM_W'(old_r) : SUM_W'(0);
  assign old_sq_ext = has_old ? SQ_W'(old_sq) : SQ_W'(0);
  assign mem_we     = (state_r == F_UPD);

  assign in_ready  = (state_r == F_IDLE);
  assign job_valid = (state_r == F_PUSH);
  assign job_sum   = sum_r;
  assign job_sq    = sq_r;
  assign job_w     = w_eff;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    x_sq_nxt  = x_sq_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    case (state_r)
      F_IDLE: begin
        if (hist_clear || (in_valid && in_start)) begin
          wp_nxt   = '0;
          fill_nxt = '0;
          sum_nxt  = '0;
          sq_nxt   = '0;
        end
        if (in_valid) begin
          x_nxt     = in_sample;
          state_nxt = F_READ;
        end
      end
      F_READ: begin
        x_sq_nxt  = x_r * x_r;
        state_nxt = F_UPD;
      end
      F_UPD: begin
        sum_nxt  = sum_r + SUM_W'(x_r) - old_ext;
        sq_nxt   = sq_r + SQ_W'(x_sq_r) - old_sq_ext;
        wp_nxt   = (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
        fill_nxt = has_old ? fill_r : fill_r + 1'b1;
        if ((wl_ext >= 32'd2) && (fill_nxt >= w_eff)) begin
          state_nxt = F_PUSH;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    x_sq_r <= x_sq_nxt;
    if (state_r == F_READ) begin
      old_r <= ring_mem[rd_idx];
    end
    if (mem_we) begin
      ring_mem[wp_r] <= x_r;
    end
  end

endmodule

>>> sv/rwv_back.sv
// ----------------------------------------------------------------------------
// Volatility back end
// Forms the variance numerator, divides it bit-serially, takes the integer
// square root two radicand bits per cycle, scales and saturates the result.
// ----------------------------------------------------------------------------
module rwv_back #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         job_valid,
  output logic                                         job_ready,
  input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0] job_sum,
  input  logic [2*SAMPLE_BITS-2+$clog2(MAX_WINDOW):0]  job_sq,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]              job_w,
  input  logic [rwv_pkg::SCALE_W-1:0]                  annual_scale,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [rwv_pkg::OUT_W-1:0]                    out_vol,
  output logic                                         out_sat
);

  import rwv_pkg::*;

  localparam int PTR_W    = $clog2(MAX_WINDOW);
  localparam int W_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = SAMPLE_BITS + PTR_W;
  localparam int SQ_W     = 2 * SAMPLE_BITS - 1 + PTR_W;
  localparam int NUM_W    = SQ_W + W_W;
  localparam int DEN_W    = 2 * W_W;
  localparam int VAR_W    = NUM_W + (NUM_W % 2);
  localparam int ROOT_W   = VAR_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int PROD_W   = ROOT_W + SCALE_W;
  localparam int PROD_X_W = (PROD_W > FRAC_BITS + OUT_W) ? PROD_W : FRAC_BITS + OUT_W + 1;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_MUL   = 7'b0000010,
    B_NUM   = 7'b0000100,
    B_DIV   = 7'b0001000,
    B_SQRT  = 7'b0010000,
    B_SCALE = 7'b0100000,
    B_OUT   = 7'b1000000
  } bstate_t;

  bstate_t               state_r, state_nxt;
  logic [SUM_W-1:0]      abs_r, abs_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [W_W-1:0]        w_r, w_nxt;
  logic [NUM_W-1:0]      wq_r, wq_nxt;
  logic [2*SUM_W-1:0]    ssq_r, ssq_nxt;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic [NUM_W-1:0]      quo_r, quo_nxt;
  logic [DEN_W-1:0]      rem_r, rem_nxt;
  logic [VAR_W-1:0]      rad_r, rad_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [SREM_W-1:0]     srem_r, srem_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [OUT_W-1:0]      vol_r, vol_nxt;
  logic                  sat_r, sat_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic [DEN_W:0]        div_sh;
  logic                  div_bit;
  logic [SREM_W+1:0]     sq_sh;
  logic [SREM_W+1:0]     sq_trial;
  logic [PROD_X_W-1:0]   prod_x;
  logic [PROD_X_W-FRAC_BITS-1:0] shifted;

  assign div_sh   = {rem_r, quo_r[NUM_W-1]};
  assign div_bit  = (div_sh >= {1'b0, den_r});
  assign sq_sh    = {srem_r, rad_r[VAR_W-1 -: 2]};
  assign sq_trial = (SREM_W+2)'({root_r, 2'b01});
  assign prod_x   = PROD_X_W'(prod_r);
  assign shifted  = prod_x[PROD_X_W-1:FRAC_BITS];

  assign job_ready = (state_r == B_IDLE);
  assign out_valid = ovalid_r;
  assign out_vol   = vol_r;
  assign out_sat   = sat_r;

  always_comb begin
    state_nxt  = state_r;
    abs_nxt    = abs_r;
    sq_nxt     = sq_r;
    w_nxt      = w_r;
    wq_nxt     = wq_r;
    ssq_nxt    = ssq_r;
    den_nxt    = den_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    srem_nxt   = srem_r;
    prod_nxt   = prod_r;
    cnt_nxt    = cnt_r;
    vol_nxt    = vol_r;
    sat_nxt    = sat_r;
    ovalid_nxt = ovalid_r && !out_ready;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          abs_nxt   = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
          sq_nxt    = job_sq;
          w_nxt     = job_w;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        wq_nxt    = w_r * sq_r;
        ssq_nxt   = abs_r * abs_r;
        den_nxt   = w_r * (w_r - 1'b1);
        state_nxt = B_NUM;
      end
      B_NUM: begin
        quo_nxt   = wq_r - NUM_W'(ssq_r);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(NUM_W);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        rem_nxt = div_bit ? DEN_W'(div_sh - {1'b0, den_r}) : div_sh[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], div_bit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          rad_nxt   = VAR_W'(quo_nxt);
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = CNT_W'(ROOT_W);
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        if (sq_sh >= sq_trial) begin
          srem_nxt = SREM_W'(sq_sh - sq_trial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = SREM_W'(sq_sh);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        rad_nxt = rad_r << 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = B_SCALE;
        end
      end
      B_SCALE: begin
        prod_nxt  = root_r * annual_scale;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!ovalid_r || out_ready) begin
          sat_nxt    = |shifted[PROD_X_W-FRAC_BITS-1:OUT_W];
          vol_nxt    = sat_nxt ? {OUT_W{1'b1}} : shifted[OUT_W-1:0];
          ovalid_nxt = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    abs_r  <= abs_nxt;
    sq_r   <= sq_nxt;
    w_r    <= w_nxt;
    wq_r   <= wq_nxt;
    ssq_r  <= ssq_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
    vol_r  <= vol_nxt;
    sat_r  <= sat_nxt;
  end

endmodule

>>> sv/rolling_window_volatility.sv
// ----------------------------------------------------------------------------
// Rolling window volatility
// Annualized sample standard deviation over the last W returns of a series.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata: return_sample; tuser: series_start
//  out_     master     tdata: volatility; tuser: saturated
//  cfg_     slave      cfg_index, cfg_data (0: window_length, 1: annual_scale)
//
//  The front end takes each transaction through a read and an update state for
//  the ring and sums, and a push state to hand a job to the two-entry queue.
//  The back end forms each result with a one-bit-per-cycle divider and square
//  root, and takes no new job until that result is in the output register.
//  Reset is synchronous and active low and clears all history.
//  A stalled output holds its result while the next transaction is computed.
// ----------------------------------------------------------------------------
module rolling_window_volatility #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // return_sample
  input  logic                                   in_tuser,   // series_start
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [rwv_pkg::OUT_W-1:0]              out_tdata,  // volatility
  output logic                                   out_tuser,  // saturated
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rwv_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rwv_pkg::CFG_DATA_W-1:0]         cfg_data
);

  import rwv_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int W_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + PTR_W;
  localparam int JOB_W  = SUM_W + SQ_W + W_W;

  logic [WLEN_W-1:0]   wlen_r, wlen_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic                hist_clear;
  logic                cfg_fire;

  logic                fq_valid, fq_ready;
  logic signed [SUM_W-1:0] f_sum;
  logic [SQ_W-1:0]     f_sq;
  logic [W_W-1:0]      f_w;
  logic [JOB_W-1:0]    push_data, pop_data;
  logic                qb_valid, qb_ready;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    wlen_nxt   = wlen_r;
    scale_nxt  = scale_r;
    hist_clear = 1'b0;
    if (cfg_fire) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          wlen_nxt   = cfg_data[WLEN_W-1:0];
          hist_clear = 1'b1;
        end
        REG_ANNUAL_SCALE: begin
          scale_nxt = cfg_data[SCALE_W-1:0];
        end
        default: begin
          wlen_nxt = wlen_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WLEN_RESET;
      scale_r <= SCALE_RESET;
    end else begin
      wlen_r  <= wlen_nxt;
      scale_r <= scale_nxt;
    end
  end

  rwv_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_sample     (in_tdata[SAMPLE_BITS-1:0]),
    .in_start      (in_tuser),
    .window_length (wlen_r),
    .hist_clear    (hist_clear),
    .job_valid     (fq_valid),
    .job_ready     (fq_ready),
    .job_sum       (f_sum),
    .job_sq        (f_sq),
    .job_w         (f_w)
  );

  assign push_data = {f_w, f_sq, f_sum};

  rwv_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (push_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (pop_data)
  );

  rwv_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (qb_valid),
    .job_ready    (qb_ready),
    .job_sum      (pop_data[SUM_W-1:0]),
    .job_sq       (pop_data[SUM_W+SQ_W-1:SUM_W]),
    .job_w        (pop_data[JOB_W-1:SUM_W+SQ_W]),
    .annual_scale (scale_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_vol      (out_tdata),
    .out_sat      (out_tuser)
  );

endmodule
